### sv/gear_hash_chunk_boundary_assert.svh
// Assertion macros for the chunk boundary RTL.
`ifndef GEAR_HASH_CHUNK_BOUNDARY_ASSERT_SVH
`define GEAR_HASH_CHUNK_BOUNDARY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GHCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GHCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ghcb_pkg.sv
// Types, constants and the gear table for the chunk boundary finder.
package ghcb_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int FP_W      = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

  // Register reset values
  localparam logic [REG_W-1:0] MIN_LEN_RST = 24'd2048;
  localparam logic [REG_W-1:0] AVG_LEN_RST = 24'd8192;
  localparam logic [REG_W-1:0] MAX_LEN_RST = 24'd65536;

  // Cut reason codes
  localparam logic [1:0] REASON_MATCH = 2'd0;
  localparam logic [1:0] REASON_MAX   = 2'd1;
  localparam logic [1:0] REASON_END   = 2'd2;

  // Gear table generator constants
  localparam logic [FP_W-1:0] GEAR_SEED = 64'h9E3779B185EBCA87;
  localparam logic [FP_W-1:0] GEAR_MUL  = 64'h2545F4914F6CDD1D;
  localparam int              GEAR_SHR  = 12;
  localparam int              GEAR_DEPTH = 256;

  typedef logic [FP_W-1:0] gear_tab_t [GEAR_DEPTH];

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [REG_W-1:0] min_len;
    logic [REG_W-1:0] max_len;
    logic [REG_W-1:0] mask;
  } cfg_t;

  // Build the gear table by the xorshift-multiply sequence
  function automatic gear_tab_t gen_gear();
    gear_tab_t       t;
    logic [FP_W-1:0] s;
    s = GEAR_SEED;
    for (int i = 0; i < GEAR_DEPTH; i++) begin
      s    = (s ^ (s >> GEAR_SHR)) * GEAR_MUL;
      t[i] = s;
    end
    return t;
  endfunction

  localparam gear_tab_t GEAR_TAB = gen_gear();

  // Match mask from the average size: (2^b)-1, b = floor(log2 avg) - 2
  function automatic logic [REG_W-1:0] mask_from_avg(input logic [REG_W-1:0] avg);
    logic [REG_W-1:0] s;
    logic [REG_W-1:0] m;
    s = avg;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    if (avg[REG_W-1:2] != '0) begin
      m = s >> 3;
    end else if (avg[1]) begin
      m = {{(REG_W-1){1'b0}}, 1'b1};
    end else begin
      m = '0;
    end
    return m;
  endfunction

  localparam logic [REG_W-1:0] MASK_RST = mask_from_avg(AVG_LEN_RST);

endpackage

### sv/ghcb_cfg_regs.sv
// Configuration registers and match mask derivation.
module ghcb_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ghcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ghcb_pkg::REG_W-1:0]       cfg_wdata,
  output ghcb_pkg::cfg_t                   cfg
);
  import ghcb_pkg::*;

  logic [REG_W-1:0] min_len_r, min_len_nxt;
  logic [REG_W-1:0] max_len_r, max_len_nxt;
  logic [REG_W-1:0] mask_r, mask_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    min_len_nxt = min_len_r;
    max_len_nxt = max_len_r;
    mask_nxt    = mask_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_LEN: min_len_nxt = cfg_wdata;
        CFG_AVG_LEN: mask_nxt    = mask_from_avg(cfg_wdata);
        CFG_MAX_LEN: max_len_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
      mask_r    <= MASK_RST;
    end else begin
      min_len_r <= min_len_nxt;
      max_len_r <= max_len_nxt;
      mask_r    <= mask_nxt;
    end
  end

  assign cfg.min_len = min_len_r;
  assign cfg.max_len = max_len_r;
  assign cfg.mask    = mask_r;

endmodule

### sv/gear_hash_chunk_boundary.sv
// Gear content-defined chunk boundary finder, top level.
//
// Input channel: one data byte per transaction (in_data_byte), with
// in_end_of_data set on the final byte of a buffer; in_valid/in_stall.
// Result channel: one transaction per chunk cut, giving its start offset,
// length and reason (0 fingerprint match, 1 maximum length, 2 end of data);
// out_valid/out_stall. Bytes that do not close a chunk give no result.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the minimum length (0),
// average length (1) and maximum length (2); write only while the block is idle.
// Timing: a byte taken into the input register is hashed there and its result,
// if any, is loaded into the result register. Throughput: one byte per cycle
// unless a result waits under out_stall; the loop is the 64-bit fingerprint
// update with its gear table lookup, length compares and cut.
// Stall: while a result waits under out_stall, a byte in the input register
// holds, whether or not it closes a chunk, and in_stall is high; the stall
// is released in the cycle the result is taken.
// Reset: clears fingerprint, chunk start and length, empties both stages
// and restores the register defaults (2048, 8192, 65536).
module gear_hash_chunk_boundary #(
  parameter int OFFSET_BITS = 48,
  parameter int LENGTH_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_end_of_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [OFFSET_BITS-1:0]         out_chunk_offset,
  output logic [LENGTH_BITS-1:0]         out_chunk_length,
  output logic [1:0]                     out_cut_reason,
  input  logic                           cfg_wr_en,
  input  logic [ghcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghcb_pkg::REG_W-1:0]     cfg_wdata
);
  import ghcb_pkg::*;

  `include "gear_hash_chunk_boundary_assert.svh"

  localparam int CMP_W = (LENGTH_BITS > REG_W) ? LENGTH_BITS : REG_W;
  localparam logic [LENGTH_BITS-1:0] LEN_FULL = '1;

  cfg_t cfg;

  ghcb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eod_r;

  // Chunk state
  logic [FP_W-1:0]        fp_r, fp_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] out_offset_r;
  logic [LENGTH_BITS-1:0] out_length_r;
  logic [1:0]             out_reason_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   adv;
  logic [FP_W-1:0]        fp_step;
  logic [LENGTH_BITS-1:0] len;
  logic                   match;
  logic                   at_max;
  logic                   cut;
  logic [1:0]             reason;

  // Handshake: the result register parts the two sides
  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Roll the fingerprint and test for a cut
  assign fp_step = {fp_r[FP_W-2:0], 1'b0}
                 | ({{(FP_W-1){1'b0}}, fp_r[FP_W-1]} ^ GEAR_TAB[s1_byte_r]);
  assign len     = count_r + LENGTH_BITS'(1);
  assign match   = (CMP_W'(len) >= CMP_W'(cfg.min_len))
                && ((fp_step[REG_W-1:0] & cfg.mask) == '0);
  assign at_max  = (CMP_W'(len) >= CMP_W'(cfg.max_len)) || (len == LEN_FULL);
  assign cut     = match || at_max || s1_eod_r;

  // Lowest reason code wins
  always_comb begin
    priority if (match) begin
      reason = REASON_MATCH;
    end else if (at_max) begin
      reason = REASON_MAX;
    end else begin
      reason = REASON_END;
    end
  end

  // Advance the chunk state
  always_comb begin
    fp_nxt    = fp_r;
    start_nxt = start_r;
    count_nxt = count_r;
    if (adv) begin
      if (cut) begin
        fp_nxt    = '0;
        start_nxt = start_r + OFFSET_BITS'(len);
        count_nxt = '0;
      end else begin
        fp_nxt    = fp_step;
        count_nxt = len;
      end
    end
  end

  // Valid flags of both stages
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = cut;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fp_r        <= '0;
      start_r     <= '0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fp_r        <= fp_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
    end
  end

  // Payload registers: capture the byte, load a finished chunk
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_data_byte;
      s1_eod_r  <= in_end_of_data;
    end
    if (adv && cut) begin
      out_offset_r <= start_r;
      out_length_r <= len;
      out_reason_r <= reason;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_offset = out_offset_r;
  assign out_chunk_length = out_length_r;
  assign out_cut_reason   = out_reason_r;

  // Checks on the chunk bookkeeping
  `GHCB_ASSERT_NEXT(a_cut_clears, adv && cut, (count_r == '0) && (fp_r == '0), "state not cleared")
  `GHCB_ASSERT_NEXT(a_start_moves, adv && cut, start_r == $past(start_nxt), "start not advanced")
  `GHCB_ASSERT_NOW(a_len_nonzero, out_valid_r, out_length_r != '0, "result with zero length")
  `GHCB_ASSERT_NOW(a_count_bound, 1'b1, count_r != LEN_FULL, "length counter full")
  `GHCB_ASSERT_NOW(a_stall_src, in_stall, s1_valid_r && out_valid_r, "stall with free pipeline")

endmodule
